>>> src/gsm7p_pkg.sv
// ----------------------------------------------------------------------------
// gsm7p_pkg
// Shared types, constants and the character mapping of the septet packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsm7p_pkg;

  // result queue geometry
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // most results one text byte can cause
  localparam int unsigned GRP_MAX = 3;

  // character codes
  localparam logic [6:0] ESC_SEPTET  = 7'h1B;
  localparam logic [6:0] QMARK       = 7'h3F;
  localparam logic [7:0] MAX_SEPT_RST = 8'd160;
  localparam logic [7:0] SEPT_SAT    = 8'hFF;

  // one input transaction
  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] octet;
    logic       octet_valid;
    logic       end_of_message;
    logic [7:0] septet_total;
    logic       too_long;
  } out_item_t;

  // results caused by one input byte, in delivery order
  typedef struct packed {
    logic [1:0]                n;
    out_item_t [GRP_MAX-1:0]   item;
  } res_grp_t;

  // Latin-1 to GSM 7-bit default alphabet; bit 7 marks an extension character
  function automatic logic [7:0] gsm_map(input logic [7:0] b);
    logic [7:0] code;
    unique case (b)
      8'h0A: code = 8'h0A;
      8'h0C: code = 8'h8A;
      8'h0D: code = 8'h0D;
      8'h24: code = 8'h02;
      8'h40: code = 8'h00;
      8'h5B: code = 8'hBC;
      8'h5C: code = 8'hAF;
      8'h5D: code = 8'hBE;
      8'h5E: code = 8'h94;
      8'h5F: code = 8'h11;
      8'h7B: code = 8'hA8;
      8'h7C: code = 8'hC0;
      8'h7D: code = 8'hA9;
      8'h7E: code = 8'hBD;
      8'hA1: code = 8'h40;
      8'hA3: code = 8'h01;
      8'hA4: code = 8'h24;
      8'hA5: code = 8'h03;
      8'hA7: code = 8'h5F;
      8'hBF: code = 8'h60;
      8'hC4: code = 8'h5B;
      8'hC5: code = 8'h0E;
      8'hC6: code = 8'h1C;
      8'hC7: code = 8'h09;
      8'hC9: code = 8'h1F;
      8'hD1: code = 8'h5D;
      8'hD6: code = 8'h5C;
      8'hD8: code = 8'h0B;
      8'hDC: code = 8'h5E;
      8'hDF: code = 8'h1E;
      8'hE0: code = 8'h7F;
      8'hE4: code = 8'h7B;
      8'hE5: code = 8'h0F;
      8'hE6: code = 8'h1D;
      8'hE8: code = 8'h04;
      8'hE9: code = 8'h05;
      8'hEC: code = 8'h07;
      8'hF1: code = 8'h7D;
      8'hF2: code = 8'h08;
      8'hF6: code = 8'h7C;
      8'hF8: code = 8'h0C;
      8'hF9: code = 8'h06;
      8'hFC: code = 8'h7E;
      default: begin
        // space through Z and a through z map onto themselves, everything else is a question mark
        if (((b >= 8'h20) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A))) begin
          code = b;
        end else begin
          code = {1'b0, QMARK};
        end
      end
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> src/gsm7p_pack.sv
// ----------------------------------------------------------------------------
// gsm7p_pack
// Character mapping, utf-8 lead handling and septet packing for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsm7p_pack
  import gsm7p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   item,
  input  wire logic       advance,
  input  wire logic [7:0] max_septets,
  output res_grp_t        grp
);

  logic [6:0] pend_r;
  logic [2:0] pcnt_r;
  logic [1:0] skip_r;
  logic [7:0] sept_r;

  logic [6:0] pend_nxt;
  logic [2:0] pcnt_nxt;
  logic [1:0] skip_nxt;
  logic [7:0] sept_nxt;

  logic [7:0]  map_code;
  logic        skip_act;
  logic        lead2;
  logic        lead3;
  logic        ext;
  logic        plain;
  logic [6:0]  sep0;
  logic [6:0]  sep1;
  logic [4:0]  shift1;
  logic [22:0] acc;
  logic [4:0]  bit_cnt;
  logic [1:0]  nfull;
  logic [2:0]  rem_cnt;
  logic [6:0]  rem_bits;
  logic [1:0]  nsep;
  logic [8:0]  sum;
  logic [7:0]  total;
  logic        tl;
  logic        flush_en;
  logic [1:0]  n_data;
  logic [1:0]  n_res;
  logic [7:0]  slot [GRP_MAX];

  // map the byte and decide how many septets it yields
  always_comb begin
    map_code = gsm_map(item.text_byte);
    skip_act = (skip_r != 2'd0);
    lead2    = (item.text_byte[7:5] == 3'b110);
    lead3    = (item.text_byte[7:4] == 4'b1110);
    ext      = !skip_act && map_code[7];
    plain    = !skip_act && !map_code[7];
    sep0     = ext ? ESC_SEPTET : ((lead2 || lead3) ? QMARK : map_code[6:0]);
    sep1     = map_code[6:0];
    nsep     = ext ? 2'd2 : (plain ? 2'd1 : 2'd0);
  end

  // lsb-first accumulation of up to two septets behind the pending bits
  always_comb begin
    shift1  = {2'b00, pcnt_r} + 5'd7;
    acc     = {16'b0, pend_r};
    if (plain || ext) begin
      acc = acc | ({16'b0, sep0} << pcnt_r);
    end
    if (ext) begin
      acc = acc | ({16'b0, sep1} << shift1);
    end
    bit_cnt = {2'b00, pcnt_r} + (ext ? 5'd14 : (plain ? 5'd7 : 5'd0));
    nfull   = bit_cnt[4:3];
    rem_cnt = bit_cnt[2:0];
    unique case (nfull)
      2'd0:    rem_bits = acc[6:0];
      2'd1:    rem_bits = acc[14:8];
      2'd2:    rem_bits = acc[22:16];
      default: rem_bits = '0;
    endcase
  end

  // running septet count, saturating
  always_comb begin
    sum   = {1'b0, sept_r} + {7'b0, nsep};
    total = sum[8] ? SEPT_SAT : sum[7:0];
    tl    = (total > max_septets);
  end

  // assemble the result group: full octets, then flush, else an end marker
  always_comb begin
    flush_en = item.is_last && (rem_cnt != 3'd0);
    n_data   = nfull + {1'b0, flush_en};
    n_res    = (item.is_last && (n_data == 2'd0)) ? 2'd1 : n_data;
    slot[0]  = (nfull != 2'd0) ? acc[7:0] : (flush_en ? {1'b0, rem_bits} : 8'h00);
    slot[1]  = (nfull == 2'd2) ? acc[15:8] : {1'b0, rem_bits};
    slot[2]  = {1'b0, rem_bits};
    grp.n    = n_res;
    for (int k = 0; k < GRP_MAX; k++) begin
      grp.item[k].octet          = slot[k];
      grp.item[k].octet_valid    = (2'(k) < n_data);
      grp.item[k].end_of_message = item.is_last && (2'(k) == (n_res - 2'd1));
      grp.item[k].septet_total   = total;
      grp.item[k].too_long       = tl;
    end
  end

  // state after this byte; the last byte clears everything
  always_comb begin
    if (item.is_last) begin
      pend_nxt = '0;
      pcnt_nxt = '0;
      skip_nxt = '0;
      sept_nxt = '0;
    end else begin
      pend_nxt = rem_bits;
      pcnt_nxt = rem_cnt;
      sept_nxt = total;
      if (skip_act) begin
        skip_nxt = skip_r - 2'd1;
      end else if (plain && lead2) begin
        skip_nxt = 2'd1;
      end else if (plain && lead3) begin
        skip_nxt = 2'd2;
      end else begin
        skip_nxt = 2'd0;
      end
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= '0;
      skip_r <= '0;
      sept_r <= '0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      skip_r <= skip_nxt;
      sept_r <= sept_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/gsm7p_outq.sv
// ----------------------------------------------------------------------------
// gsm7p_outq
// Result queue: takes a group of up to three results, hands out one a cycle while out_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsm7p_outq
  import gsm7p_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire res_grp_t           grp,
  output logic [OUTQ_CW-1:0]      count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output out_item_t               out_data
);

  out_item_t             q_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]    head_r;
  logic [OUTQ_CW-1:0]    count_r;
  logic [OUTQ_AW-1:0]    head_nxt;
  logic [OUTQ_CW-1:0]    count_nxt;
  logic [OUTQ_AW-1:0]    wr_ptr;
  logic [1:0]            push_n;
  logic                  pop;

  // pointer arithmetic
  always_comb begin
    pop       = (count_r != '0) && !out_stall;
    push_n    = push ? grp.n : 2'd0;
    wr_ptr    = head_r + count_r[OUTQ_AW-1:0];
    head_nxt  = pop ? (head_r + OUTQ_AW'(1)) : head_r;
    count_nxt = count_r + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // entries, written in group order behind the tail
  always_ff @(posedge clk) begin
    for (int k = 0; k < GRP_MAX; k++) begin
      if (2'(k) < push_n) begin
        q_r[wr_ptr + OUTQ_AW'(k)] <= grp.item[k];
      end
    end
  end

  assign count     = count_r;
  assign out_valid = (count_r != '0);
  assign out_data  = q_r[head_r];

endmodule

`default_nettype wire

>>> src/gsm7_text_encode_pack.sv
// ----------------------------------------------------------------------------
// gsm7_text_encode_pack
// Text to GSM 7-bit default alphabet encoder with septet packing.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle. A byte passes an input register, is
// mapped and packed combinationally, and its zero to three results enter a
// four-entry result queue, from which they are offered in order. The queue
// drains one result per cycle while out_stall is low, so the rate is one
// byte per cycle as long as the bytes average at most one result each; the
// input stalls when the group of the byte held in the input register does
// not fit in the queue. Extension characters give an escape septet and the
// code, utf-8 lead bytes give a question mark and drop the following
// continuation bytes, and the last byte flushes leftover bits and ends the
// message with the septet count and the too-long flag. max_septets may be
// written only while no message byte is in flight; it resets to 160.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsm7_text_encode_pack
  import gsm7p_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  logic                  in_vld_r;
  in_item_t              in_item_r;
  logic [7:0]            max_sept_r;
  logic                  in_vld_nxt;
  logic                  in_take;
  logic                  advance;
  logic [OUTQ_CW-1:0]    q_count;
  res_grp_t              grp;

  // input register advances when its result group fits in the queue
  always_comb begin
    advance    = in_vld_r &&
                 ((OUTQ_CW + 1)'(q_count) + (OUTQ_CW + 1)'(grp.n) <= (OUTQ_CW + 1)'(OUTQ_DEPTH));
    in_stall   = in_vld_r && !advance;
    in_take    = in_valid && !in_stall;
    in_vld_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  end

  // input register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      max_sept_r <= MAX_SEPT_RST;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_we) begin
        max_sept_r <= cfg_wdata;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_data;
    end
  end

  // mapping and packing
  gsm7p_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (in_item_r),
    .advance     (advance),
    .max_septets (max_sept_r),
    .grp         (grp)
  );

  // result queue
  gsm7p_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .grp       (grp),
    .count     (q_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue never overfills
  a_q_bound : assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= OUTQ_CW'(OUTQ_DEPTH))
    else $error("result queue overfilled");

  // the last byte of a message always produces at least one result
  a_last_res : assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.is_last) |-> (grp.n != 2'd0))
    else $error("last byte produced no result");

  // a pure end marker carries a zero octet and ends the message
  a_marker : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.octet_valid) |->
      (out_data.end_of_message && (out_data.octet == 8'h00)))
    else $error("malformed end marker");

endmodule

`default_nettype wire
